[hw/rtl/ctir_pkg.sv]
// shared types and constants for the interface adapter timer and interrupt registers
// no dependencies
package ctir_pkg;

   // command codes carried by a request
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_RAISE = 2'd3
   } ctir_command_type;

   localparam int RegCount = 16;
   localparam int IndexWidth = $clog2(RegCount);

   // register indexes with special meaning
   localparam logic [IndexWidth-1:0] IDX_TLO = 4'd4;
   localparam logic [IndexWidth-1:0] IDX_THI = 4'd5;
   localparam logic [IndexWidth-1:0] IDX_ICR = 4'd13;

   localparam logic [7:0] REG_RESET_VALUE = 8'hFF;
   localparam logic [7:0] ICR_ACTIVE_BIT = 8'h80;
   localparam logic [6:0] MASK_BITS = 7'h7F;

   typedef struct packed {
      ctir_command_type       command;
      logic [IndexWidth-1:0]  reg_index;
      logic [7:0]             write_data;
      logic [7:0]             source_bits;
   } ctir_request_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       cpu_irq;
   } ctir_result_type;

endpackage

[hw/rtl/ctir_channels.sv]
// valid/ready channel interfaces for requests and results
// depends on ctir_pkg
interface ctir_req_if import ctir_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            command;
   logic [IndexWidth-1:0] reg_index;
   logic [7:0]            write_data;
   logic [7:0]            source_bits;

   modport source (output valid, command, reg_index, write_data, source_bits, input ready);
   modport sink (input valid, command, reg_index, write_data, source_bits, output ready);
endinterface

interface ctir_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       cpu_irq;

   modport source (output valid, read_data, cpu_irq, input ready);
   modport sink (input valid, read_data, cpu_irq, output ready);
endinterface

[hw/rtl/cia_timer_interrupt_registers_top.sv]
// top level of the interface adapter timer and interrupt registers
// depends on ctir_pkg, ctir_channels and ctir_core

// Each request (read, write, timer tick or interrupt raise) is taken when it is offered
// and ready is high, and its result appears in the output register in the next cycle;
// a new request is accepted every cycle as long as the result register is empty or being
// drained, so the sustained rate is one request per clock. All state updates are done in
// the accepting cycle, so back-to-back requests always see the effect of the one before.
module cia_timer_interrupt_registers_top import ctir_pkg::*; (
   input logic        clock,
   input logic        reset,
   ctir_req_if.sink   req,
   ctir_rsp_if.source rsp
);

   logic             accept;
   ctir_request_type request;
   ctir_result_type  result;

   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   ctir_result_type rsp_data_ff;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept = req.valid && req.ready;

   assign request.command = ctir_command_type'(req.command);
   assign request.reg_index = req.reg_index;
   assign request.write_data = req.write_data;
   assign request.source_bits = req.source_bits;

   ctir_core u_core (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .request (request),
      .result  (result)
   );

   // result register
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.read_data = rsp_data_ff.read_data;
   assign rsp.cpu_irq = rsp_data_ff.cpu_irq;

   // every accepted request produces a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp.valid)
      else $error("accepted request gave no result");

   // only a tick may raise the cpu interrupt
   assert property (@(posedge clock) disable iff (reset)
      accept && req.command != CMD_TICK |=> !rsp.cpu_irq)
      else $error("cpu interrupt on a non-tick request");

   // read data is zero except for reads
   assert property (@(posedge clock) disable iff (reset)
      accept && req.command != CMD_READ |=> rsp.read_data == 8'd0)
      else $error("non-zero read data on a non-read request");

endmodule

[hw/rtl/ctir_core.sv]
// register file, timer a counter, reload latch and interrupt mask with their update logic
// depends on ctir_pkg
module ctir_core import ctir_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  ctir_request_type request,
   output ctir_result_type  result
);

   logic [7:0]  reg_file_ff [RegCount];
   logic [7:0]  reg_file_in [RegCount];
   logic [15:0] reload_ff;
   logic [15:0] reload_in;
   logic [6:0]  enable_ff;
   logic [6:0]  enable_in;

   logic [15:0] count_dec;
   logic [7:0]  icr_raised;

   assign count_dec = {reg_file_ff[IDX_THI], reg_file_ff[IDX_TLO]} - 16'd1;
   assign icr_raised = reg_file_ff[IDX_ICR] | request.source_bits;

   // next state and result for the accepted request
   always_comb begin
      reg_file_in = reg_file_ff;
      reload_in = reload_ff;
      enable_in = enable_ff;
      result = '0;
      case (request.command)
         CMD_READ: begin
            result.read_data = reg_file_ff[request.reg_index];
            if (request.reg_index == IDX_ICR) begin
               reg_file_in[IDX_ICR] = '0;
            end
         end
         CMD_WRITE: begin
            if (request.reg_index == IDX_TLO) begin
               reload_in[7:0] = request.write_data;
            end else if (request.reg_index == IDX_THI) begin
               reload_in[15:8] = request.write_data;
            end else if (request.reg_index == IDX_ICR) begin
               if ((request.write_data & ICR_ACTIVE_BIT) != 8'd0) begin
                  enable_in = enable_ff | (request.write_data[6:0] & MASK_BITS);
               end else begin
                  enable_in = enable_ff & ~(request.write_data[6:0] & MASK_BITS);
               end
            end else begin
               reg_file_in[request.reg_index] = request.write_data;
            end
         end
         CMD_TICK: begin
            if (count_dec == 16'd0) begin
               reg_file_in[IDX_THI] = reload_ff[15:8];
               reg_file_in[IDX_TLO] = reload_ff[7:0];
               reg_file_in[IDX_ICR] = reg_file_ff[IDX_ICR] | 8'h01;
               result.cpu_irq = enable_ff[0];
            end else begin
               reg_file_in[IDX_THI] = count_dec[15:8];
               reg_file_in[IDX_TLO] = count_dec[7:0];
            end
         end
         CMD_RAISE: begin
            if ((enable_ff & request.source_bits[6:0]) != 7'd0) begin
               reg_file_in[IDX_ICR] = icr_raised | ICR_ACTIVE_BIT;
            end else begin
               reg_file_in[IDX_ICR] = icr_raised;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

   // state registers, updated only on an accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) begin
            reg_file_ff[i] <= REG_RESET_VALUE;
         end
         reload_ff <= '0;
         enable_ff <= '0;
      end else if (accept) begin
         reg_file_ff <= reg_file_in;
         reload_ff <= reload_in;
         enable_ff <= enable_in;
      end
   end

   // reading the interrupt control register leaves it clear
   assert property (@(posedge clock) disable iff (reset)
      accept && request.command == CMD_READ && request.reg_index == IDX_ICR
      |=> reg_file_ff[IDX_ICR] == 8'd0)
      else $error("icr not cleared after read");

   // writes to the timer indexes reach only the reload latch
   assert property (@(posedge clock) disable iff (reset)
      accept && request.command == CMD_WRITE
      && (request.reg_index == IDX_TLO || request.reg_index == IDX_THI)
      |=> $stable(reg_file_ff[IDX_TLO]) && $stable(reg_file_ff[IDX_THI]))
      else $error("timer write disturbed the counter");

   // an interrupt pulse always leaves timer pending bit set
   assert property (@(posedge clock) disable iff (reset)
      accept && result.cpu_irq |=> reg_file_ff[IDX_ICR][0])
      else $error("cpu interrupt without pending timer flag");

endmodule
